[design/rcsfd_pkg.sv]
// Shared types and constants for the RC satellite frame decoder.
// No dependencies; every other design file but rcsfd_if.sv imports this package.
package rcsfd_pkg;

	localparam int DATA_BITS    = 11;
	localparam int MASK_BITS    = 16;
	localparam int OUT_CHANNELS = 6;
	localparam int HEADER_BYTES = 2;
	localparam int ADDR_W       = 4;
	localparam int CONF_W       = 8;

	localparam logic [3:0]        UNUSED_CHANNEL = 4'd15;
	localparam logic [CONF_W-1:0] COUNT_SAT      = 8'd255;

	localparam logic [CONF_W-1:0] CONF_MAX_RESET   = 8'd10;
	localparam logic [CONF_W-1:0] CONF_THR_RESET   = 8'd5;
	localparam logic [CONF_W-1:0] FRAMES_RPT_RESET = 8'd2;

	typedef logic [DATA_BITS-1:0] data_t;
	typedef logic [MASK_BITS-1:0] mask_t;
	typedef logic [CONF_W-1:0]    conf_t;

	typedef enum logic [2:0] {
		ST_COMPLETE  = 3'd0,
		ST_TIMEOUT   = 3'd1,
		ST_SHORT     = 3'd2,
		ST_DUPLICATE = 3'd3,
		ST_UNKNOWN   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		REG_CONF_MAX   = 2'd0,
		REG_CONF_THR   = 2'd1,
		REG_FRAMES_RPT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		conf_t conf_max;
		conf_t conf_thr;
		conf_t frames_rpt;
	} cfg_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] data_byte;
	} item_t;

	// Frame assembler view of the frame in progress.
	typedef struct packed {
		mask_t seen_mask;
		logic  dup;
		logic  full;
	} frame_t;

	// Layout table view for the gap in progress.
	typedef struct packed {
		logic  trusted;
		logic  known;
		mask_t avail_next;
	} layout_t;

	typedef struct packed {
		data_t [OUT_CHANNELS-1:0] chan;
		logic                     link_ok;
		status_t                  status;
	} result_t;

endpackage

[design/rcsfd_if.sv]
// Request and result channel interfaces of the RC satellite frame decoder.
// No dependencies.
interface rcsfd_rx_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] data_byte;

	modport source(output valid, mode, data_byte, input ready);
	modport sink(input valid, mode, data_byte, output ready);
endinterface

interface rcsfd_report_if;
	logic        valid;
	logic        ready;
	logic [10:0] throttle;
	logic [10:0] roll;
	logic [10:0] pitch;
	logic [10:0] yaw;
	logic [10:0] flap;
	logic [10:0] gear;
	logic        link_ok;
	logic [2:0]  status;

	modport source(output valid, throttle, roll, pitch, yaw, flap, gear, link_ok, status,
		input ready);
	modport sink(input valid, throttle, roll, pitch, yaw, flap, gear, link_ok, status,
		output ready);
endinterface

[design/rc_satellite_frame_decoder.sv]
// RC satellite serial frame decoder, top level.
// A gap request passes through the input stage register, then the result register.
// Throughput: one request per cycle while results drain; while a result is
// blocked, the input stage holds one request and then refuses further requests.
// Reset: arst_n clears counters, slot table, merged set and valid flags at once;
// no clearing pass is needed.
module rc_satellite_frame_decoder #(
	parameter int LAYOUT_SLOTS = 4,
	parameter int FRAME_BYTES  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	rcsfd_rx_if.sink                       rx,
	rcsfd_report_if.source                 report,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [rcsfd_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import rcsfd_pkg::*;

	cfg_t    cfg_q;
	logic    item_valid_s1;
	item_t   item_s1;
	logic    fire;
	logic    learn;
	frame_t  frame;
	data_t [OUT_CHANNELS-1:0] staged;
	layout_t lay;
	logic    res_valid;
	result_t res;

	// Configuration registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.conf_max   <= CONF_MAX_RESET;
			cfg_q.conf_thr   <= CONF_THR_RESET;
			cfg_q.frames_rpt <= FRAMES_RPT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				REG_CONF_MAX:   cfg_q.conf_max   <= pwdata[7:0];
				REG_CONF_THR:   cfg_q.conf_thr   <= pwdata[7:0];
				REG_FRAMES_RPT: cfg_q.frames_rpt <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_CONF_MAX:   prdata = {24'd0, cfg_q.conf_max};
			REG_CONF_THR:   prdata = {24'd0, cfg_q.conf_thr};
			REG_FRAMES_RPT: prdata = {24'd0, cfg_q.frames_rpt};
			default:        prdata = '0;
		endcase
	end

	// Input stage: advance whenever the result register is free or drains.
	assign fire     = item_valid_s1 && (!res_valid || report.ready);
	assign rx.ready = !item_valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			item_valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			item_s1.mode      <= rx.mode;
			item_s1.data_byte <= rx.data_byte;
		end
	end

	rcsfd_frame_asm #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_frame_asm (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.frame  (frame),
		.staged (staged)
	);

	assign learn = fire && item_s1.mode && frame.full && !lay.trusted;

	rcsfd_layout_tbl #(
		.LAYOUT_SLOTS(LAYOUT_SLOTS)
	) u_layout_tbl (
		.clk    (clk),
		.arst_n (arst_n),
		.learn  (learn),
		.mask   (frame.seen_mask),
		.cfg    (cfg_q),
		.lay    (lay)
	);

	rcsfd_report u_report (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.gap        (item_s1.mode),
		.frame      (frame),
		.staged     (staged),
		.lay        (lay),
		.frames_rpt (cfg_q.frames_rpt),
		.res_ready  (report.ready),
		.res_valid  (res_valid),
		.res        (res)
	);

	assign report.valid    = res_valid;
	assign report.throttle = res.chan[0];
	assign report.roll     = res.chan[1];
	assign report.pitch    = res.chan[2];
	assign report.yaw      = res.chan[3];
	assign report.flap     = res.chan[4];
	assign report.gear     = res.chan[5];
	assign report.link_ok  = res.link_ok;
	assign report.status   = res.status;

endmodule

[design/rcsfd_frame_asm.sv]
// Frame assembler: counts bytes, pairs them into channel words, stages values.
// Depends on rcsfd_pkg.
module rcsfd_frame_asm #(
	parameter int FRAME_BYTES = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  fire,
	input  rcsfd_pkg::item_t                      item,
	output rcsfd_pkg::frame_t                     frame,
	output rcsfd_pkg::data_t [rcsfd_pkg::OUT_CHANNELS-1:0] staged
);
	import rcsfd_pkg::*;

	localparam int CW = $clog2(FRAME_BYTES + 1);

	logic [CW-1:0] count_q;
	logic [7:0]    high_q;
	mask_t         seen_q;
	logic          dup_q;
	data_t         staged_q [OUT_CHANNELS];

	logic       take;
	logic       in_body;
	logic       low_byte;
	logic [3:0] word_ch;
	data_t      word_data;
	logic       used;
	logic       repeat_ch;
	logic       store;

	always_comb begin
		word_ch   = high_q[6:3];
		word_data = {high_q[2:0], item.data_byte};
		take      = fire && !item.mode && (count_q < CW'(FRAME_BYTES));
		in_body   = count_q >= CW'(HEADER_BYTES);
		low_byte  = take && in_body && count_q[0];
		used      = low_byte && (word_ch != UNUSED_CHANNEL);
		repeat_ch = used && seen_q[word_ch];
		store     = used && !seen_q[word_ch];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			high_q  <= '0;
			seen_q  <= '0;
			dup_q   <= 1'b0;
		end else if (fire && item.mode) begin
			count_q <= '0;
			high_q  <= '0;
			seen_q  <= '0;
			dup_q   <= 1'b0;
		end else if (take) begin
			count_q <= count_q + CW'(1);
			if (in_body && !count_q[0]) begin
				high_q <= item.data_byte;
			end
			if (repeat_ch) begin
				dup_q <= 1'b1;
			end
			if (store) begin
				seen_q[word_ch] <= 1'b1;
			end
		end
	end

	// Only the reported channels need their values kept.
	always_ff @(posedge clk) begin
		for (int i = 0; i < OUT_CHANNELS; i++) begin
			if (store && (word_ch == 4'(i))) begin
				staged_q[i] <= word_data;
			end
		end
	end

	always_comb begin
		frame.seen_mask = seen_q;
		frame.dup       = dup_q;
		frame.full      = (count_q == CW'(FRAME_BYTES));
		for (int i = 0; i < OUT_CHANNELS; i++) begin
			staged[i] = staged_q[i];
		end
	end

endmodule

[design/rcsfd_layout_tbl.sv]
// Layout slot table: learns channel masks by confidence counting and
// tracks the trusted flag and the available channel mask. Depends on rcsfd_pkg.
module rcsfd_layout_tbl #(
	parameter int LAYOUT_SLOTS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               learn,
	input  rcsfd_pkg::mask_t   mask,
	input  rcsfd_pkg::cfg_t    cfg,
	output rcsfd_pkg::layout_t lay
);
	import rcsfd_pkg::*;

	mask_t layout_q [LAYOUT_SLOTS];
	conf_t conf_q   [LAYOUT_SLOTS];
	logic  trusted_q;
	mask_t avail_q;

	logic [LAYOUT_SLOTS-1:0] match;
	logic [LAYOUT_SLOTS-1:0] inc;
	logic [LAYOUT_SLOTS-1:0] hit;
	logic [LAYOUT_SLOTS-1:0] free;
	logic [LAYOUT_SLOTS-1:0] capture;
	logic [LAYOUT_SLOTS-1:0] evict;
	conf_t                   new_conf [LAYOUT_SLOTS];
	logic                    any_match;
	logic                    any_hit;
	logic                    taken;
	logic                    late_hit;
	mask_t                   avail_add;
	logic                    known;

	always_comb begin
		known = 1'b0;
		for (int i = 0; i < LAYOUT_SLOTS; i++) begin
			match[i]    = (layout_q[i] == mask);
			inc[i]      = match[i] && (conf_q[i] < cfg.conf_max);
			new_conf[i] = inc[i] ? conf_q[i] + conf_t'(1) : conf_q[i];
			hit[i]      = inc[i] && (new_conf[i] == cfg.conf_max);
			free[i]     = (conf_q[i] == '0);
			if (match[i] && (conf_q[i] > cfg.conf_thr)) begin
				known = 1'b1;
			end
		end
		any_match = |match;
		any_hit   = |hit;

		// A slot at or before the last hitting slot has already been bumped
		// when that slot reaches the maximum; a later slot has not.
		avail_add = '0;
		for (int j = 0; j < LAYOUT_SLOTS; j++) begin
			late_hit = |(hit >> j);
			if (any_hit && (late_hit ? (new_conf[j] > cfg.conf_thr)
					: (conf_q[j] > cfg.conf_thr))) begin
				avail_add = avail_add | layout_q[j];
			end
		end

		// Capture the first free slot, else evict every weak slot.
		taken = 1'b0;
		for (int i = 0; i < LAYOUT_SLOTS; i++) begin
			capture[i] = !any_match && free[i] && !taken;
			taken      = taken | free[i];
			evict[i]   = !any_match && !(|free) && (conf_q[i] < cfg.conf_thr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAYOUT_SLOTS; i++) begin
				layout_q[i] <= '0;
				conf_q[i]   <= '0;
			end
			trusted_q <= 1'b0;
			avail_q   <= '0;
		end else if (learn) begin
			for (int i = 0; i < LAYOUT_SLOTS; i++) begin
				if (any_match) begin
					conf_q[i] <= new_conf[i];
				end else if (capture[i]) begin
					layout_q[i] <= mask;
					conf_q[i]   <= conf_t'(1);
				end else if (evict[i]) begin
					layout_q[i] <= '0;
					conf_q[i]   <= '0;
				end
			end
			if (any_hit) begin
				trusted_q <= 1'b1;
			end
			avail_q <= avail_q | avail_add;
		end
	end

	always_comb begin
		lay.trusted    = trusted_q;
		lay.known      = known;
		lay.avail_next = learn ? (avail_q | avail_add) : avail_q;
	end

endmodule

[design/rcsfd_report.sv]
// Merge and report unit: merges accepted frames into the channel set, decides
// the status and holds the result register. Depends on rcsfd_pkg.
module rcsfd_report (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            fire,
	input  logic                                            gap,
	input  rcsfd_pkg::frame_t                               frame,
	input  rcsfd_pkg::data_t [rcsfd_pkg::OUT_CHANNELS-1:0]  staged,
	input  rcsfd_pkg::layout_t                              lay,
	input  rcsfd_pkg::conf_t                                frames_rpt,
	input  logic                                            res_ready,
	output logic                                            res_valid,
	output rcsfd_pkg::result_t                              res
);
	import rcsfd_pkg::*;

	data_t   merged_q [OUT_CHANNELS];
	mask_t   mmask_q;
	logic    complete_q;
	conf_t   fcount_q;
	logic    res_valid_q;
	result_t res_q;

	data_t   base_vals [OUT_CHANNELS];
	data_t   vals      [OUT_CHANNELS];
	mask_t   base_mask;
	mask_t   mmask_next;
	conf_t   base_cnt;
	conf_t   cnt_next;
	logic    complete_next;
	logic    report;
	status_t status;
	result_t payload;

	always_comb begin
		// Clear the merged set first when the previous report was complete.
		for (int i = 0; i < OUT_CHANNELS; i++) begin
			base_vals[i] = complete_q ? '0 : merged_q[i];
			vals[i]      = base_vals[i];
		end
		base_mask     = complete_q ? '0 : mmask_q;
		base_cnt      = complete_q ? '0 : fcount_q;
		cnt_next      = (base_cnt != COUNT_SAT) ? base_cnt + conf_t'(1) : base_cnt;
		mmask_next    = base_mask;
		complete_next = 1'b0;
		report        = 1'b1;
		status        = ST_COMPLETE;

		if (!frame.full) begin
			status = ST_SHORT;
		end else if (lay.trusted && !lay.known) begin
			status = ST_UNKNOWN;
		end else if (frame.dup) begin
			status = ST_DUPLICATE;
		end else begin
			for (int i = 0; i < OUT_CHANNELS; i++) begin
				if (frame.seen_mask[i]) begin
					vals[i] = staged[i];
				end
			end
			mmask_next = base_mask | frame.seen_mask;
			if (mmask_next == lay.avail_next) begin
				complete_next = 1'b1;
				status        = ST_COMPLETE;
			end else if (cnt_next > frames_rpt) begin
				status = ST_TIMEOUT;
			end else begin
				report = 1'b0;
			end
		end

		for (int i = 0; i < OUT_CHANNELS; i++) begin
			payload.chan[i] = vals[i];
		end
		payload.link_ok = complete_next;
		payload.status  = status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < OUT_CHANNELS; i++) begin
				merged_q[i] <= '0;
			end
			mmask_q     <= '0;
			complete_q  <= 1'b0;
			fcount_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (fire && gap) begin
				for (int i = 0; i < OUT_CHANNELS; i++) begin
					merged_q[i] <= vals[i];
				end
				mmask_q    <= mmask_next;
				complete_q <= complete_next;
				fcount_q   <= cnt_next;
			end
			if (fire && gap && report) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && gap && report) begin
			res_q <= payload;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[design/rcsfd_checker.sv]
// Port-level checks for the RC satellite frame decoder, bound to the top level.
// Depends on rcsfd_pkg and rc_satellite_frame_decoder.
module rcsfd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rx_valid,
	input logic       rx_ready,
	input logic       rx_mode,
	input logic       rep_valid,
	input logic       rep_ready,
	input logic       rep_link_ok,
	input logic [2:0] rep_status
);
	import rcsfd_pkg::*;

	// A stalled result holds its status.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rep_valid && !rep_ready |=> rep_valid && $stable(rep_status))
		else $error("result changed while stalled");

	// link_ok marks exactly the complete reports.
	a_link: assert property (@(posedge clk) disable iff (!arst_n)
		rep_valid |-> (rep_link_ok == (rep_status == ST_COMPLETE)))
		else $error("link_ok disagrees with status");

	// A new result follows a gap request accepted through the input stage register.
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rep_valid) |-> $past(rx_valid && rx_ready && rx_mode, 2))
		else $error("result without a gap request");

	// Requests are refused only while a result is blocked.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!rx_ready |-> rep_valid && !rep_ready)
		else $error("request refused without backpressure");

endmodule

bind rc_satellite_frame_decoder rcsfd_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rx_valid    (rx.valid),
	.rx_ready    (rx.ready),
	.rx_mode     (rx.mode),
	.rep_valid   (report.valid),
	.rep_ready   (report.ready),
	.rep_link_ok (report.link_ok),
	.rep_status  (report.status)
);

[tb/rc_satellite_frame_decoder_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for rc_satellite_frame_decoder: serial frames, gaps, APB setup.
// Needs rcsfd_pkg and the rcsfd_rx_if / rcsfd_report_if interfaces from the design folder.
module rc_satellite_frame_decoder_tb;
	import rcsfd_pkg::*;

	localparam int SLOTS        = 4;
	localparam int FRAME_LEN    = 16;
	localparam int CHANNELS     = 16;
	localparam int WORDS        = 7;
	localparam int SETTLE       = 8;
	localparam int HOLD_CYCLES  = 400;
	localparam int LIMIT_CYCLES = 400000;
	localparam int PHASES       = 4;
	localparam int NO_REPORT    = -1;

	localparam mask_t LAYOUT_A = 16'h003F;
	localparam mask_t LAYOUT_B = 16'h0FC0;

	localparam conf_t PH_MAX    [PHASES] = '{8'd10, 8'd1, 8'd255, 8'd4};
	localparam conf_t PH_THR    [PHASES] = '{8'd5, 8'd0, 8'd255, 8'd3};
	localparam conf_t PH_FRAMES [PHASES] = '{8'd2, 8'd1, 8'd255, 8'd8};
	localparam int    PH_ITEMS  [PHASES] = '{550, 450, 250, 550};

	// {mode, byte}: lone gap, short pair, then a full frame with a repeated
	// channel, a top-bit word, channel 14 and two bytes past the frame end
	localparam logic [8:0] DIRECTED [23] = '{
		9'h100, 9'h000, 9'h0FF, 9'h100,
		9'h0FF, 9'h000, 9'h087, 9'h0FF, 9'h000, 9'h000, 9'h070, 9'h000,
		9'h07F, 9'h0FF, 9'h0FF, 9'h0FF, 9'h078, 9'h000, 9'h0F8, 9'h001,
		9'h055, 9'h0AA, 9'h100
	};

	typedef enum int {SINK_EAGER, SINK_RANDOM, SINK_PERIODIC, SINK_COIN} sink_style_t;

	class frame_report_board;
		conf_t   cfg_max, cfg_thr, cfg_frames;
		logic [4:0] byte_cnt;
		logic [7:0] hi_byte;
		mask_t   seen_mask, merged_mask, avail_mask;
		bit      dup_flag, complete, trusted;
		data_t   staged [CHANNELS];
		data_t   merged_val [CHANNELS];
		conf_t   frame_cnt;
		mask_t   slot_mask [SLOTS];
		conf_t   slot_conf [SLOTS];
		result_t pending_reports [$];
		int      mismatches;
		int      checked;
		int      status_count [5];

		function void clear_state();
			cfg_max = CONF_MAX_RESET;
			cfg_thr = CONF_THR_RESET;
			cfg_frames = FRAMES_RPT_RESET;
			byte_cnt = '0;
			hi_byte = '0;
			seen_mask = '0;
			merged_mask = '0;
			avail_mask = '0;
			dup_flag = 0;
			complete = 0;
			trusted = 0;
			frame_cnt = '0;
			for (int i = 0; i < CHANNELS; i++) begin
				staged[i] = '0;
				merged_val[i] = '0;
			end
			for (int i = 0; i < SLOTS; i++) begin
				slot_mask[i] = '0;
				slot_conf[i] = '0;
			end
		endfunction

		function void set_register(reg_idx_t idx, conf_t v);
			case (idx)
				REG_CONF_MAX:   cfg_max = v;
				REG_CONF_THR:   cfg_thr = v;
				REG_FRAMES_RPT: cfg_frames = v;
				default: ;
			endcase
		endfunction

		function void absorb_byte(logic [7:0] b);
			logic [4:0]  idx;
			logic [15:0] word;
			logic [3:0]  ch;
			if (byte_cnt >= FRAME_LEN)
				return;
			idx = byte_cnt;
			byte_cnt = byte_cnt + 5'd1;
			if (idx < HEADER_BYTES)
				return;
			if (!idx[0]) begin
				hi_byte = b;
				return;
			end
			word = {hi_byte, b};
			ch = word[14:11];
			if (ch == UNUSED_CHANNEL)
				return;
			if (seen_mask[ch]) begin
				dup_flag = 1;
			end else begin
				staged[ch] = word[10:0];
				seen_mask[ch] = 1'b1;
			end
		endfunction

		function void train_slots(mask_t m);
			bit hit;
			hit = 0;
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_mask[i] == m) begin
					if (slot_conf[i] < cfg_max) begin
						slot_conf[i] = slot_conf[i] + conf_t'(1);
						if (slot_conf[i] == cfg_max) begin
							trusted = 1;
							for (int j = 0; j < SLOTS; j++)
								if (slot_conf[j] > cfg_thr)
									avail_mask = avail_mask | slot_mask[j];
						end
					end
					hit = 1;
				end
			end
			if (hit)
				return;
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_conf[i] == 0) begin
					slot_mask[i] = m;
					slot_conf[i] = conf_t'(1);
					return;
				end
			end
			// table full: drop every weak layout
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_conf[i] < cfg_thr) begin
					slot_mask[i] = '0;
					slot_conf[i] = '0;
				end
			end
		endfunction

		function int close_frame();
			mask_t m;
			bit    had_dup, full, known;
			m = seen_mask;
			had_dup = dup_flag;
			full = (byte_cnt == FRAME_LEN);
			byte_cnt = '0;
			hi_byte = '0;
			seen_mask = '0;
			dup_flag = 0;
			if (complete) begin
				complete = 0;
				merged_mask = '0;
				frame_cnt = '0;
				for (int i = 0; i < CHANNELS; i++)
					merged_val[i] = '0;
			end
			if (frame_cnt < COUNT_SAT)
				frame_cnt = frame_cnt + conf_t'(1);
			if (!full)
				return ST_SHORT;
			if (trusted) begin
				known = 0;
				for (int i = 0; i < SLOTS; i++)
					if (slot_mask[i] == m && slot_conf[i] > cfg_thr)
						known = 1;
				if (!known)
					return ST_UNKNOWN;
			end else begin
				train_slots(m);
			end
			if (had_dup)
				return ST_DUPLICATE;
			for (int i = 0; i < CHANNELS; i++)
				if (m[i])
					merged_val[i] = staged[i];
			merged_mask = merged_mask | m;
			if (merged_mask == avail_mask) begin
				complete = 1;
				return ST_COMPLETE;
			end
			if (frame_cnt > cfg_frames)
				return ST_TIMEOUT;
			return NO_REPORT;
		endfunction

		function void note_request(logic mode, logic [7:0] b);
			int      st;
			result_t want;
			if (!mode) begin
				absorb_byte(b);
			end else begin
				st = close_frame();
				if (st != NO_REPORT) begin
					for (int i = 0; i < OUT_CHANNELS; i++)
						want.chan[i] = merged_val[i];
					want.link_ok = complete;
					want.status = status_t'(st[2:0]);
					pending_reports.push_back(want);
				end
			end
		endfunction

		function string describe(result_t r);
			return $sformatf("ch %0d %0d %0d %0d %0d %0d link_ok %0b status %0d",
				r.chan[0], r.chan[1], r.chan[2], r.chan[3], r.chan[4], r.chan[5],
				r.link_ok, r.status);
		endfunction

		function void check_report(result_t got);
			result_t want;
			bit      bad;
			if (pending_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected report: %s", describe(got));
				return;
			end
			want = pending_reports.pop_front();
			bad = (got.link_ok !== want.link_ok) || (got.status !== want.status);
			for (int i = 0; i < OUT_CHANNELS; i++)
				if (got.chan[i] !== want.chan[i])
					bad = 1;
			checked++;
			status_count[want.status]++;
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("report mismatch, expected: %s", describe(want));
					$display("report mismatch, actual:   %s", describe(got));
				end
			end
		endfunction

		function int pending();
			return pending_reports.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        hold_off = 1'b0;

	int          cycle_count = 0;
	int          items_sent = 0;
	int          frames_sent = 0;
	int          burst_left = 0;
	sink_style_t sink_style = SINK_EAGER;
	logic        sink_take;
	result_t     observed;

	frame_report_board board;

	rcsfd_rx_if     rx_link ();
	rcsfd_report_if report_link ();

	rc_satellite_frame_decoder #(
		.LAYOUT_SLOTS(SLOTS),
		.FRAME_BYTES (FRAME_LEN)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_link.sink),
		.report (report_link.source),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// result side: stall style redrawn when the cycle counter's low byte wraps, long hold-off on top
	always @(posedge clk) begin
		if (arst_n && report_link.valid && report_link.ready) begin
			observed.chan[0] = report_link.throttle;
			observed.chan[1] = report_link.roll;
			observed.chan[2] = report_link.pitch;
			observed.chan[3] = report_link.yaw;
			observed.chan[4] = report_link.flap;
			observed.chan[5] = report_link.gear;
			observed.link_ok = report_link.link_ok;
			observed.status = status_t'(report_link.status);
			board.check_report(observed);
		end
		if (cycle_count[7:0] == 8'd0)
			sink_style = sink_style_t'($urandom_range(0, 3));
		case (sink_style)
			SINK_EAGER:    sink_take = 1'b1;
			SINK_RANDOM:   sink_take = ($urandom_range(0, 9) >= 3);
			SINK_PERIODIC: sink_take = ((cycle_count % 7) >= 3);
			default:       sink_take = 1'($urandom_range(0, 1));
		endcase
		report_link.ready <= sink_take && !hold_off;
	end

	// hold off the result side long enough for the block to back up
	initial begin
		wait (items_sent >= 400);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	task automatic offer(logic m, logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
			if (gap > 0) begin
				rx_link.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		rx_link.valid <= 1'b1;
		rx_link.mode <= m;
		rx_link.data_byte <= b;
		@(posedge clk);
		while (!rx_link.ready)
			@(posedge clk);
		board.note_request(m, b);
		items_sent++;
		burst_left--;
	endtask

	task automatic write_reg(reg_idx_t idx, conf_t v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		board.set_register(idx, v);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain(int settle);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	function automatic logic [15:0] make_word(logic [3:0] ch);
		logic [10:0] value;
		case ($urandom_range(0, 9))
			0:       value = '0;
			1:       value = '1;
			default: value = 11'($urandom);
		endcase
		return {1'($urandom), ch, value};
	endfunction

	// header, seven words in random order, optional trailing bytes, gap
	task automatic send_frame(mask_t chans, bit with_dup, int extra);
		logic [15:0] words [WORDS];
		logic [3:0]  ch_list [WORDS];
		logic [15:0] tmp;
		int n, c, k, j;
		n = 0;
		for (c = 0; c < 15; c++) begin
			if (chans[c] && n < WORDS) begin
				ch_list[n] = c[3:0];
				n++;
			end
		end
		for (k = 0; k < WORDS; k++)
			words[k] = (k < n) ? make_word(ch_list[k]) : make_word(UNUSED_CHANNEL);
		if (with_dup && n > 0 && n < WORDS)
			words[n] = make_word(ch_list[$urandom_range(0, n - 1)]);
		for (k = WORDS - 1; k > 0; k--) begin
			j = $urandom_range(0, k);
			tmp = words[k];
			words[k] = words[j];
			words[j] = tmp;
		end
		offer(1'b0, 8'($urandom));
		offer(1'b0, 8'($urandom));
		for (k = 0; k < WORDS; k++) begin
			offer(1'b0, words[k][15:8]);
			offer(1'b0, words[k][7:0]);
		end
		repeat (extra) offer(1'b0, 8'($urandom));
		offer(1'b1, 8'($urandom));
		frames_sent++;
	endtask

	task automatic send_random_frame();
		int    pick, n, extra;
		mask_t layout, odd;
		pick = $urandom_range(0, 99);
		extra = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 3) : 0;
		layout = frames_sent[0] ? LAYOUT_B : LAYOUT_A;
		if (pick < 70) begin
			send_frame(layout, 1'b0, extra);
		end else if (pick < 78) begin
			send_frame(layout, 1'b1, extra);
		end else if (pick < 86) begin
			odd = '0;
			repeat ($urandom_range(0, WORDS)) odd[$urandom_range(0, 14)] = 1'b1;
			send_frame(odd, 1'($urandom_range(0, 1)), extra);
		end else begin
			// short frames and plain noise, some long enough to count as full
			n = (pick < 93) ? $urandom_range(0, FRAME_LEN - 1) : $urandom_range(0, 24);
			repeat (n) offer(1'b0, 8'($urandom));
			offer(1'b1, 8'($urandom));
			frames_sent++;
		end
	endtask

	initial begin
		int phase_start;
		board = new();
		board.clear_state();
		arst_n <= 1'b0;
		rx_link.valid <= 1'b0;
		rx_link.mode <= 1'b0;
		rx_link.data_byte <= 8'd0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < PHASES; ph++) begin
			write_reg(REG_CONF_MAX, PH_MAX[ph]);
			write_reg(REG_CONF_THR, PH_THR[ph]);
			write_reg(REG_FRAMES_RPT, PH_FRAMES[ph]);
			if (ph == 0)
				foreach (DIRECTED[i])
					offer(DIRECTED[i][8], DIRECTED[i][7:0]);
			phase_start = items_sent;
			while (items_sent - phase_start < PH_ITEMS[ph])
				send_random_frame();
			// drop valid and let the block go idle before touching registers
			rx_link.valid <= 1'b0;
			burst_left = 0;
			drain(SETTLE);
		end

		$display("covered %0d requests in %0d frames over %0d register settings, %0d reports",
			items_sent, frames_sent, PHASES, board.checked);
		$display("report mix: complete %0d, timeout %0d, short %0d, duplicate %0d, unknown %0d",
			board.status_count[ST_COMPLETE], board.status_count[ST_TIMEOUT],
			board.status_count[ST_SHORT], board.status_count[ST_DUPLICATE],
			board.status_count[ST_UNKNOWN]);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatching reports, %0d still expected",
				board.mismatches, board.pending());
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
